// ----- rtl/aescts_pkg.sv -----
// aescts_pkg: shared types, register indexes, S-box tables and AES round
// functions for the AES-128 CBC ciphertext-stealing engine.
// No dependencies.
package aescts_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_KEY_HIGH = 3'd0;
  localparam logic [2:0] REG_KEY_LOW  = 3'd1;
  localparam logic [2:0] REG_IV_HIGH  = 3'd2;
  localparam logic [2:0] REG_IV_LOW   = 3'd3;
  localparam logic [2:0] REG_DECRYPT  = 3'd4;

  localparam int BLOCK_BYTES = 16;
  localparam int NUM_ROUNDS  = 10;

  typedef struct packed {
    logic [63:0] in_high;
    logic [63:0] in_low;
    logic [4:0]  in_bytes;
    logic        in_last;
  } in_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic [4:0]  out_bytes;
    logic        out_last;
    logic        error;
  } out_t;

  // Control from the sequencer to the round unit
  typedef struct packed {
    logic load;
    logic step;
    logic dec;
    logic fin;
  } core_ctrl_t;

  typedef logic [7:0] sbox_t [256];

  localparam sbox_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Inverse S-box, built at elaboration
  function automatic sbox_t build_inv();
    sbox_t r;
    for (int i = 0; i < 256; i++) r[SBOX[i]] = 8'(i);
    return r;
  endfunction

  localparam sbox_t INV_SBOX = build_inv();

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    logic [7:0] y;
    p = 8'h00;
    x = a;
    y = b;
    for (int i = 0; i < 8; i++) begin
      if (y[0]) p = p ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
      y = {1'b0, y[7:1]};
    end
    return p;
  endfunction

  function automatic logic [7:0] rcon_of(logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // One step of the key schedule: next round key from the previous one
  function automatic logic [127:0] key_next(logic [127:0] k, logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // Encrypt round: SubBytes, ShiftRows, MixColumns unless final, AddRoundKey
  function automatic logic [127:0] enc_round(logic [127:0] s, logic [127:0] k, logic fin);
    logic [7:0] t [16];
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        t[c*4+w] = SBOX[s[127 - 8*(((c + w) & 3)*4 + w) -: 8]];
    for (int c = 0; c < 4; c++) begin
      if (fin) begin
        for (int j = 0; j < 4; j++) r[127 - 8*(c*4+j) -: 8] = t[c*4+j];
      end else begin
        r[127 - 8*(c*4+0) -: 8] = gmul(t[c*4], 8'd2) ^ gmul(t[c*4+1], 8'd3)
                                  ^ t[c*4+2] ^ t[c*4+3];
        r[127 - 8*(c*4+1) -: 8] = t[c*4] ^ gmul(t[c*4+1], 8'd2)
                                  ^ gmul(t[c*4+2], 8'd3) ^ t[c*4+3];
        r[127 - 8*(c*4+2) -: 8] = t[c*4] ^ t[c*4+1] ^ gmul(t[c*4+2], 8'd2)
                                  ^ gmul(t[c*4+3], 8'd3);
        r[127 - 8*(c*4+3) -: 8] = gmul(t[c*4], 8'd3) ^ t[c*4+1] ^ t[c*4+2]
                                  ^ gmul(t[c*4+3], 8'd2);
      end
    end
    return r ^ k;
  endfunction

  // Decrypt round: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns unless final
  function automatic logic [127:0] dec_round(logic [127:0] s, logic [127:0] k, logic fin);
    logic [127:0] u;
    logic [127:0] r;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        u[127 - 8*(((c + w) & 3)*4 + w) -: 8] = INV_SBOX[s[127 - 8*(c*4+w) -: 8]];
    u = u ^ k;
    r = u;
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = u[127 - 8*(c*4+0) -: 8];
        a1 = u[127 - 8*(c*4+1) -: 8];
        a2 = u[127 - 8*(c*4+2) -: 8];
        a3 = u[127 - 8*(c*4+3) -: 8];
        r[127 - 8*(c*4+0) -: 8] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11)
                                  ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
        r[127 - 8*(c*4+1) -: 8] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14)
                                  ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
        r[127 - 8*(c*4+2) -: 8] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9)
                                  ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
        r[127 - 8*(c*4+3) -: 8] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13)
                                  ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
      end
    end
    return r;
  endfunction

  // Keep the leading n bytes, zero the rest
  function automatic logic [127:0] mask_bytes(logic [127:0] v, logic [4:0] n);
    logic [127:0] r;
    r = v;
    for (int i = 0; i < BLOCK_BYTES; i++)
      if (5'(i) >= n) r[127 - 8*i -: 8] = 8'h00;
    return r;
  endfunction

  // Leading n bytes from a, the rest from b
  function automatic logic [127:0] merge_bytes(logic [127:0] a, logic [127:0] b,
                                               logic [4:0] n);
    logic [127:0] r;
    for (int i = 0; i < BLOCK_BYTES; i++)
      r[127 - 8*i -: 8] = (5'(i) < n) ? a[127 - 8*i -: 8] : b[127 - 8*i -: 8];
    return r;
  endfunction

  function automatic out_t make_out(logic [127:0] v, logic [4:0] n, logic last,
                                    logic err);
    out_t o;
    o.out_high  = v[127:64];
    o.out_low   = v[63:0];
    o.out_bytes = n;
    o.out_last  = last;
    o.error     = err;
    return o;
  endfunction

endpackage

// ----- rtl/aescts_keyexp.sv -----
// aescts_keyexp: iterative AES-128 key schedule, one round key per cycle,
// held in an 11-entry register file. Depends on aescts_pkg.
module aescts_keyexp (
  input  logic         clk,
  input  logic         rst,
  input  logic [127:0] key,
  input  logic         key_write,
  input  logic         start,
  input  logic [3:0]   rd_sel,
  output logic [127:0] rd_key,
  output logic         keys_ok
);

  logic [127:0] rk [11];
  logic [127:0] kcur;
  logic [3:0]   kc;
  logic         busy;
  logic [127:0] knext;

  assign knext  = aescts_pkg::key_next(kcur, aescts_pkg::rcon_of(kc));
  assign rd_key = rk[rd_sel];

  // Schedule control; a key write invalidates the stored schedule
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      keys_ok <= 1'b0;
      kc      <= 4'd0;
    end else if (key_write) begin
      busy    <= 1'b0;
      keys_ok <= 1'b0;
    end else if (busy) begin
      kc <= kc + 4'd1;
      if (kc == 4'(aescts_pkg::NUM_ROUNDS)) begin
        busy    <= 1'b0;
        keys_ok <= 1'b1;
      end
    end else if (start && !keys_ok) begin
      busy <= 1'b1;
      kc   <= 4'd1;
    end
  end

  // Round key storage
  always_ff @(posedge clk) begin
    if (!busy && start && !keys_ok && !key_write) begin
      rk[0] <= key;
      kcur  <= key;
    end else if (busy) begin
      rk[kc] <= knext;
      kcur   <= knext;
    end
  end

endmodule

// ----- rtl/aescts_core.sv -----
// aescts_core: shared AES round unit with its state register; one round
// per cycle in either direction. Depends on aescts_pkg.
module aescts_core (
  input  logic                   clk,
  input  aescts_pkg::core_ctrl_t ctrl,
  input  logic [127:0]           din,
  input  logic [127:0]           rkey,
  output logic [127:0]           st
);

  // Load applies the initial key; each step runs one round
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      st <= din ^ rkey;
    end else if (ctrl.step) begin
      st <= ctrl.dec ? aescts_pkg::dec_round(st, rkey, ctrl.fin)
                     : aescts_pkg::enc_round(st, rkey, ctrl.fin);
    end
  end

endmodule

// ----- rtl/aes128_cbc_cts_engine.sv -----
// aes128_cbc_cts_engine: AES-128 CBC engine with ciphertext stealing.
// Depends on aescts_pkg, aescts_keyexp, aescts_core.
//
//   channel   signals                        dir   transfer when
//   input     in_valid/in_ready/in_data      in    in_valid && in_ready
//   output    out_valid/out_ready/out_data   out   out_valid && out_ready
//   config    cfg_we/cfg_addr/cfg_wdata      in    cfg_we
//
// One block at a time: accept; unless the block is an error or is only
// held, a check of the key schedule and one or two AES passes (load, ten
// rounds, finish); then one result per cycle while out_ready is high.
// After a key write the first block also waits for the key schedule.
// Sync reset clears the held block and invalidates the key schedule.
// in_ready is low from accept until the last result has transferred, or
// until the pass ends if there is no result; a held block keeps it high.
module aes128_cbc_cts_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aescts_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output aescts_pkg::out_t  out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [63:0]       cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KEYX = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [4:0] FULL = 5'(aescts_pkg::BLOCK_BYTES);
  localparam logic [3:0] LAST_RND = 4'(aescts_pkg::NUM_ROUNDS);

  logic [2:0]   state;
  logic [63:0]  key_high, key_low, iv_high, iv_low;
  logic         dmode;
  logic [127:0] blk, chain, held, nxt;
  logic [4:0]   nbytes;
  logic         last, mode, pass, hv;
  logic [3:0]   cnt;
  aescts_pkg::out_t res [2];
  logic [1:0]   ocnt;
  logic         oidx;

  logic         acc;
  logic [4:0]   nn;
  logic         err;
  logic [127:0] in_blk;
  logic         key_write;
  logic         keys_ok;
  logic [3:0]   rsel;
  logic [127:0] rkey, core_din, core_st, dval, ymix;
  aescts_pkg::core_ctrl_t ctrl;

  assign in_ready  = (state == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_valid = (state == S_OUT);
  assign out_data  = res[oidx];

  // Input qualification
  assign nn     = (in_data.in_bytes > FULL) ? FULL : in_data.in_bytes;
  assign err    = (nn == 5'd0) || ((nn != FULL) && !in_data.in_last)
                  || ((nn != FULL) && dmode && !hv);
  assign in_blk = aescts_pkg::mask_bytes({in_data.in_high, in_data.in_low}, nn);

  assign key_write = cfg_we && (cfg_addr == aescts_pkg::REG_KEY_HIGH
                                || cfg_addr == aescts_pkg::REG_KEY_LOW);

  // Round unit control and key select
  assign rsel      = mode ? (LAST_RND - cnt) : cnt;
  assign ctrl.load = (state == S_RUN) && (cnt == 4'd0);
  assign ctrl.step = (state == S_RUN) && (cnt != 4'd0);
  assign ctrl.dec  = mode;
  assign ctrl.fin  = (cnt == LAST_RND);
  assign core_din  = pass ? nxt : (mode ? held : (blk ^ chain));
  assign dval      = core_st ^ chain;
  assign ymix      = aescts_pkg::merge_bytes(blk, core_st, nbytes);

  aescts_keyexp u_keyexp (
    .clk       (clk),
    .rst       (rst),
    .key       ({key_high, key_low}),
    .key_write (key_write),
    .start     (state == S_KEYX),
    .rd_sel    (rsel),
    .rd_key    (rkey),
    .keys_ok   (keys_ok)
  );

  aescts_core u_core (
    .clk  (clk),
    .ctrl (ctrl),
    .din  (core_din),
    .rkey (rkey),
    .st   (core_st)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= 64'd0;
      key_low  <= 64'd0;
      iv_high  <= 64'd0;
      iv_low   <= 64'd0;
      dmode    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        aescts_pkg::REG_KEY_HIGH: key_high <= cfg_wdata;
        aescts_pkg::REG_KEY_LOW:  key_low  <= cfg_wdata;
        aescts_pkg::REG_IV_HIGH:  iv_high  <= cfg_wdata;
        aescts_pkg::REG_IV_LOW:   iv_low   <= cfg_wdata;
        aescts_pkg::REG_DECRYPT:  dmode    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hv    <= 1'b0;
      held  <= 128'd0;
      cnt   <= 4'd0;
      pass  <= 1'b0;
      ocnt  <= 2'd0;
      oidx  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            blk    <= in_blk;
            nxt    <= in_blk;
            nbytes <= nn;
            last   <= in_data.in_last;
            mode   <= dmode;
            chain  <= hv ? chain : {iv_high, iv_low};
            ocnt   <= err ? 2'd1 : 2'd0;
            oidx   <= 1'b0;
            cnt    <= 4'd0;
            if (err) begin
              res[0] <= aescts_pkg::make_out(128'd0, 5'd0, 1'b1, 1'b1);
              hv     <= 1'b0;
              state  <= S_OUT;
            end else if (dmode && nn == FULL && !hv && !in_data.in_last) begin
              // first ciphertext block of a message is only held
              held <= in_blk;
              hv   <= 1'b1;
            end else begin
              pass  <= dmode && !hv;
              state <= S_KEYX;
            end
          end
        end
        S_KEYX: begin
          if (keys_ok) state <= S_RUN;
        end
        S_RUN: begin
          cnt <= cnt + 4'd1;
          if (cnt == LAST_RND) state <= S_FIN;
        end
        S_FIN: begin
          cnt <= 4'd0;
          if (!mode) begin
            // encrypt: core_st is the new ciphertext
            if (nbytes == FULL) begin
              res[0] <= hv ? aescts_pkg::make_out(held, FULL, 1'b0, 1'b0)
                           : aescts_pkg::make_out(core_st, FULL, 1'b1, 1'b0);
              res[1] <= aescts_pkg::make_out(core_st, FULL, 1'b1, 1'b0);
              ocnt   <= {1'b0, hv} + {1'b0, last};
              chain  <= core_st;
              if (!last) begin
                held <= core_st;
                hv   <= 1'b1;
              end else begin
                hv <= 1'b0;
              end
              state <= (hv || last) ? S_OUT : S_IDLE;
            end else begin
              res[0] <= aescts_pkg::make_out(core_st, FULL, !hv, 1'b0);
              res[1] <= aescts_pkg::make_out(aescts_pkg::mask_bytes(held, nbytes),
                                             nbytes, 1'b1, 1'b0);
              ocnt   <= {1'b0, hv} + 2'd1;
              hv     <= 1'b0;
              state  <= S_OUT;
            end
          end else if (!pass) begin
            // decrypt, first pass over the held block
            if (nbytes == FULL) begin
              res[0] <= aescts_pkg::make_out(dval, FULL, 1'b0, 1'b0);
              ocnt   <= 2'd1;
              chain  <= held;
              if (last) begin
                pass  <= 1'b1;
                state <= S_RUN;
              end else begin
                held  <= blk;
                state <= S_OUT;
              end
            end else begin
              // stolen tail rebuilt here, padded block decrypted next
              res[1] <= aescts_pkg::make_out(
                          aescts_pkg::mask_bytes(core_st ^ ymix, nbytes),
                          nbytes, 1'b1, 1'b0);
              nxt    <= ymix;
              pass   <= 1'b1;
              state  <= S_RUN;
            end
          end else begin
            // decrypt, second pass
            if (nbytes == FULL) begin
              res[ocnt[0]] <= aescts_pkg::make_out(dval, FULL, 1'b1, 1'b0);
              ocnt         <= ocnt + 2'd1;
            end else begin
              res[0] <= aescts_pkg::make_out(dval, FULL, 1'b0, 1'b0);
              ocnt   <= 2'd2;
            end
            hv    <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (({1'b0, oidx} + 2'd1) == ocnt) begin
              state <= S_IDLE;
            end else begin
              oidx <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- test/testbench.sv -----
// testbench: self-checking bench for aes128_cbc_cts_engine (AES-128 CBC with
// ciphertext stealing). A block-level predictor computes the expected results.
// Depends on aescts_pkg and the engine RTL.
module testbench;

  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS  = 240;
  localparam int NUM_PHASES   = 8;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;

  typedef struct {
    bit               dec;
    aescts_pkg::in_t  d;
    bit               typed;
    aescts_pkg::out_t want;
  } row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  aescts_pkg::in_t   in_data;
  logic              out_valid;
  logic              out_ready;
  aescts_pkg::out_t  out_data;
  logic              cfg_we;
  logic [2:0]        cfg_addr;
  logic [63:0]       cfg_wdata;

  aes128_cbc_cts_engine u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Shadow of the engine: registers, held block, chaining value
  bit [127:0] key_r, iv_r, held_blk, chain_blk;
  bit         dec_r, held_v;
  bit [127:0] sched [11];
  bit [7:0]   inv_sb [256];

  aescts_pkg::out_t pending_blocks[$];
  aescts_pkg::out_t fresh[$];
  int    fails;
  idle_t idle_mode;
  int    hold_left;
  row_t  rows[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Limit on the whole run
  initial begin
    #(8 * 3000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------- AES arithmetic ----------------
  function automatic bit [7:0] xt(bit [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic bit [7:0] fmul(bit [7:0] a, bit [7:0] b);
    bit [7:0] p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xt(a);
    end
    return p;
  endfunction

  function automatic bit [7:0] byte_at(bit [127:0] v, int i);
    return v[127 - 8*i -: 8];
  endfunction

  // Round keys from the current key register
  function automatic void expand_key();
    bit [7:0] rc;
    bit [31:0] w [44];
    bit [31:0] t;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key_r[127 - 32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {aescts_pkg::SBOX[t[23:16]] ^ rc, aescts_pkg::SBOX[t[15:8]],
             aescts_pkg::SBOX[t[7:0]], aescts_pkg::SBOX[t[31:24]]};
        rc = xt(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic bit [127:0] aes_enc(bit [127:0] s);
    bit [7:0] t [16];
    bit [7:0] a0, a1, a2, a3;
    s ^= sched[0];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++)
          t[c*4+w] = aescts_pkg::SBOX[byte_at(s, ((c + w) & 3)*4 + w)];
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        if (r < 10) begin
          s[127 - 8*(c*4)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
          s[127 - 8*(c*4+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
          s[127 - 8*(c*4+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
          s[127 - 8*(c*4+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end else begin
          s[127 - 8*(c*4) -: 32] = {a0, a1, a2, a3};
        end
      end
      s ^= sched[r];
    end
    return s;
  endfunction

  function automatic bit [127:0] aes_dec(bit [127:0] s);
    bit [127:0] u;
    bit [7:0] a0, a1, a2, a3;
    s ^= sched[10];
    for (int r = 9; r >= 0; r--) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++)
          u[127 - 8*(((c + w) & 3)*4 + w) -: 8] = inv_sb[byte_at(s, c*4 + w)];
      s = u ^ sched[r];
      if (r > 0) begin
        for (int c = 0; c < 4; c++) begin
          a0 = byte_at(s, c*4); a1 = byte_at(s, c*4+1);
          a2 = byte_at(s, c*4+2); a3 = byte_at(s, c*4+3);
          s[127 - 8*(c*4)   -: 8] = fmul(a0, 8'd14) ^ fmul(a1, 8'd11)
                                    ^ fmul(a2, 8'd13) ^ fmul(a3, 8'd9);
          s[127 - 8*(c*4+1) -: 8] = fmul(a0, 8'd9) ^ fmul(a1, 8'd14)
                                    ^ fmul(a2, 8'd11) ^ fmul(a3, 8'd13);
          s[127 - 8*(c*4+2) -: 8] = fmul(a0, 8'd13) ^ fmul(a1, 8'd9)
                                    ^ fmul(a2, 8'd14) ^ fmul(a3, 8'd11);
          s[127 - 8*(c*4+3) -: 8] = fmul(a0, 8'd11) ^ fmul(a1, 8'd13)
                                    ^ fmul(a2, 8'd9) ^ fmul(a3, 8'd14);
        end
      end
    end
    return s;
  endfunction

  // Keep the leading n bytes
  function automatic bit [127:0] keep_lead(bit [127:0] v, int n);
    for (int i = n; i < 16; i++) v[127 - 8*i -: 8] = 8'h00;
    return v;
  endfunction

  function automatic void emit(bit [127:0] v, int n, bit last, bit err);
    aescts_pkg::out_t o;
    o.out_high  = v[127:64];
    o.out_low   = v[63:0];
    o.out_bytes = 5'(n);
    o.out_last  = last;
    o.error     = err;
    fresh.push_back(o);
  endfunction

  // ---------------- CTS predictor: fills fresh with the results of one block
  function automatic void cts_predict(aescts_pkg::in_t d);
    int n;
    bit [127:0] blk, x, y;
    fresh.delete();
    expand_key();
    n = (d.in_bytes > 16) ? 16 : int'(d.in_bytes);
    if (!held_v) chain_blk = iv_r;
    if (n == 0 || (n < 16 && !d.in_last) || (n < 16 && dec_r && !held_v)) begin
      held_v = 0;
      emit('0, 0, 1'b1, 1'b1);
      return;
    end
    blk = keep_lead({d.in_high, d.in_low}, n);
    if (!dec_r) begin
      x = aes_enc(blk ^ chain_blk);
      if (n == 16) begin
        if (held_v) emit(held_blk, 16, 1'b0, 1'b0);
        chain_blk = x;
        if (d.in_last) begin
          emit(x, 16, 1'b1, 1'b0);
          held_v = 0;
        end else begin
          held_blk = x;
          held_v = 1;
        end
      end else begin
        emit(x, 16, !held_v, 1'b0);
        if (held_v) emit(keep_lead(held_blk, n), n, 1'b1, 1'b0);
        held_v = 0;
      end
    end else if (n == 16) begin
      if (held_v) begin
        emit(aes_dec(held_blk) ^ chain_blk, 16, 1'b0, 1'b0);
        chain_blk = held_blk;
      end
      if (d.in_last) begin
        emit(aes_dec(blk) ^ chain_blk, 16, 1'b1, 1'b0);
        held_v = 0;
      end else begin
        held_blk = blk;
        held_v = 1;
      end
    end else begin
      // short final block: rebuild the stolen tail
      x = aes_dec(held_blk);
      y = x;
      for (int i = 0; i < n; i++) y[127 - 8*i -: 8] = byte_at(blk, i);
      x ^= y;
      y = aes_dec(y) ^ chain_blk;
      emit(y, 16, 1'b0, 1'b0);
      emit(keep_lead(x, n), n, 1'b1, 1'b0);
      held_v = 0;
    end
  endfunction

  // ---------------- drivers ----------------
  task automatic cfg_write(logic [2:0] a, logic [63:0] v);
    cfg_we = 1'b1; cfg_addr = a; cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (a)
      aescts_pkg::REG_KEY_HIGH: key_r[127:64] = v;
      aescts_pkg::REG_KEY_LOW:  key_r[63:0]   = v;
      aescts_pkg::REG_IV_HIGH:  iv_r[127:64]  = v;
      aescts_pkg::REG_IV_LOW:   iv_r[63:0]    = v;
      aescts_pkg::REG_DECRYPT:  dec_r         = v[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid = 1'b0;
    wait (pending_blocks.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 47;
      IDLE_BOTH: return $urandom_range(0, 99) < 6;
      default:   return 1'b0;
    endcase
  endfunction

  // Offer one block; on transfer predict it (typed expectation if given)
  task automatic send(aescts_pkg::in_t d, bit typed = 0, aescts_pkg::out_t want = '0);
    while (sender_gap()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = d;
    do @(posedge clk); while (!in_ready);
    cts_predict(d);
    if (typed) pending_blocks.push_back(want);
    else foreach (fresh[i]) pending_blocks.push_back(fresh[i]);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic aescts_pkg::in_t mk(logic [63:0] h, logic [63:0] l, int n, bit last);
    aescts_pkg::in_t d;
    d.in_high = h; d.in_low = l; d.in_bytes = 5'(n); d.in_last = last;
    return d;
  endfunction

  task automatic add_row(bit dec, aescts_pkg::in_t d, bit typed = 0,
                         aescts_pkg::out_t want = '0);
    row_t r;
    r.dec = dec; r.d = d; r.typed = typed; r.want = want;
    rows.push_back(r);
  endtask

  // ---------------- receiver ----------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      case (idle_mode)
        IDLE_RECV: out_ready <= $urandom_range(0, 99) >= 47;
        IDLE_BOTH: out_ready <= $urandom_range(0, 99) >= 6;
        default:   out_ready <= 1'b1;
      endcase
    end
  end

  // Compare each transfer with the oldest expectation
  always @(posedge clk) begin
    aescts_pkg::out_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_blocks.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        fails++;
      end else begin
        e = pending_blocks.pop_front();
        if (out_data.out_high !== e.out_high) begin
          $error("out_high exp %h got %h", e.out_high, out_data.out_high); fails++;
        end
        if (out_data.out_low !== e.out_low) begin
          $error("out_low exp %h got %h", e.out_low, out_data.out_low); fails++;
        end
        if (out_data.out_bytes !== e.out_bytes) begin
          $error("out_bytes exp %0d got %0d", e.out_bytes, out_data.out_bytes); fails++;
        end
        if (out_data.out_last !== e.out_last) begin
          $error("out_last exp %b got %b", e.out_last, out_data.out_last); fails++;
        end
        if (out_data.error !== e.error) begin
          $error("error exp %b got %b", e.error, out_data.error); fails++;
        end
      end
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    aescts_pkg::out_t err_res, zero_ct;
    aescts_pkg::in_t d;
    int cnt, len, r;
    logic [63:0] kh, kl, ih, il;
    for (int i = 0; i < 256; i++) inv_sb[aescts_pkg::SBOX[i]] = 8'(i);
    fails = 0; idle_mode = IDLE_NONE; hold_left = 0;
    rst = 1'b1; in_valid = 1'b0; in_data = '0; out_ready = 1'b1;
    cfg_we = 1'b0; cfg_addr = aescts_pkg::REG_KEY_HIGH; cfg_wdata = '0;
    key_r = '0; iv_r = '0; dec_r = 0; held_blk = '0; chain_blk = '0; held_v = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    err_res = '{out_high: '0, out_low: '0, out_bytes: 5'd0, out_last: 1'b1, error: 1'b1};
    // zero key, zero IV, zero block: the well-known AES-128 test vector
    zero_ct = '{out_high: 64'h66e94bd4ef8a2c3b, out_low: 64'h884cfa59ca342b2e,
                out_bytes: 5'd16, out_last: 1'b1, error: 1'b0};

    // Directed rows (reset configuration, then decrypt)
    add_row(0, mk('0, '0, 16, 1), 1, zero_ct);
    add_row(0, mk('1, '1, 0, 1), 1, err_res);
    add_row(0, mk(rnd64(), rnd64(), 5, 0), 1, err_res);
    add_row(0, mk('1, '1, 1, 1));
    add_row(0, mk('1, '1, 31, 1));
    add_row(0, mk('1, '1, 16, 0));
    add_row(0, mk(rnd64(), rnd64(), 16, 0));
    add_row(0, mk(rnd64(), rnd64(), 15, 1));
    add_row(0, mk('0, '0, 16, 0));
    add_row(0, mk('1, '0, 16, 1));
    add_row(0, mk(rnd64(), rnd64(), 16, 0));
    add_row(0, mk(rnd64(), rnd64(), 1, 1));
    add_row(1, mk(rnd64(), rnd64(), 7, 1), 1, err_res);
    add_row(1, mk(rnd64(), rnd64(), 16, 0));
    add_row(1, mk(rnd64(), rnd64(), 16, 1));
    add_row(1, mk(rnd64(), rnd64(), 16, 0));
    add_row(1, mk(rnd64(), rnd64(), 9, 1));
    add_row(1, mk('1, '1, 16, 0));
    add_row(1, mk('1, '1, 15, 1));
    add_row(1, mk('0, '0, 0, 0), 1, err_res);
    add_row(1, mk(rnd64(), rnd64(), 16, 0));
    add_row(1, mk(rnd64(), rnd64(), 3, 0), 1, err_res);

    foreach (rows[i]) begin
      if (rows[i].dec != dec_r) begin
        drain();
        cfg_write(aescts_pkg::REG_DECRYPT, {63'd0, rows[i].dec});
      end
      send(rows[i].d, rows[i].typed, rows[i].want);
    end

    // Random phases, each with its own key, IV, mode and idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      kh = (p == 1) ? '1 : (p == 0) ? '0 : rnd64();
      kl = (p == 1) ? '1 : (p == 0) ? '0 : rnd64();
      ih = (p == 2) ? '1 : (p == 0) ? '0 : rnd64();
      il = (p == 2) ? '1 : (p == 0) ? '0 : rnd64();
      cfg_write(aescts_pkg::REG_KEY_HIGH, kh);
      cfg_write(aescts_pkg::REG_KEY_LOW, kl);
      cfg_write(aescts_pkg::REG_IV_HIGH, ih);
      cfg_write(aescts_pkg::REG_IV_LOW, il);
      cfg_write(aescts_pkg::REG_DECRYPT, {63'd0, p[0]});
      idle_mode = idle_t'(p % 4);
      if (p == 5) hold_left = 400;
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        // sender waits for the engine to empty once mid-run
        if (p == 3 && cnt == PHASE_ITEMS / 2) begin
          in_valid = 1'b0;
          wait (pending_blocks.size() == 0);
          @(negedge clk);
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
          d = mk(rnd64(), rnd64(), $urandom_range(0, 31), 1'($urandom_range(0, 1)));
          send(d);
          cnt++;
        end else begin
          len = $urandom_range(1, 5);
          for (int k = 1; k < len; k++) begin
            send(mk(rnd64(), rnd64(), 16, 0));
            cnt++;
          end
          send(mk(rnd64(), rnd64(),
                  ($urandom_range(0, 2) == 0) ? 16 : $urandom_range(1, 15), 1));
          cnt++;
        end
      end
    end

    drain();
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/aescts_pkg.sv
rtl/aescts_keyexp.sv
rtl/aescts_core.sv
rtl/aes128_cbc_cts_engine.sv
test/testbench.sv
